[hw/rtl/mm_pkg.sv]
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared payload types, operation and register codes, and the control
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mm_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;

  // Fixed field widths of the channels.
  localparam int OP_W      = 2;
  localparam int POS_W     = 3;
  localparam int IN_VAL_W  = 16;
  localparam int OUT_VAL_W = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W     = 64;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]            operation;
    logic [POS_W-1:0]           elem_row;
    logic [POS_W-1:0]           elem_col;
    logic signed [IN_VAL_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]            out_row;
    logic [POS_W-1:0]            out_col;
    logic signed [OUT_VAL_W-1:0] out_value;
    logic                        status;
    logic                        last;
  } out_item_t;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             issue;
    logic             first;
    logic             last_n;
    logic             load_out;
    logic             load_err;
    logic             out_last;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_done;
    logic slot_free;
  } dp_status_t;

endpackage

[hw/rtl/mm_ctrl.sv]
// ----------------------------------------------------------------------------
// Matrix multiply controller
// Holds the dimension registers, takes input items and walks the row,
// column and inner-dimension counters that drive the datapath.
// ----------------------------------------------------------------------------
module mm_ctrl #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mm_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mm_pkg::in_item_t              in_data_i,
  input  mm_pkg::dp_status_t            status_i,
  output mm_pkg::dp_cmd_t               cmd_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr_a_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr_b_o
);

  localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);
  localparam int CW     = mm_pkg::CFG_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_ERR   = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [CW-1:0] r_q, r_d, c_q, c_d, n_q, n_d;
  logic [CW-1:0] ar, ac, br, bc;
  logic          accept, in_range, dims_bad, last_n, last_elem;

  function automatic logic [CW-1:0] clamp_dim(input logic [CW-1:0] d);
    logic [CW-1:0] res;
    res = d;
    if (32'(d) > MAX_DIM) begin
      res = CW'(MAX_DIM);
    end
    return res;
  endfunction

  assign ar = clamp_dim(a_rows_q);
  assign ac = clamp_dim(a_cols_q);
  assign br = clamp_dim(b_rows_q);
  assign bc = clamp_dim(b_cols_q);

  assign dims_bad = (ar == '0) || (ac == '0) || (br == '0) || (bc == '0) || (ac != br);

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(in_data_i.elem_row) < MAX_DIM) &&
                      (32'(in_data_i.elem_col) < MAX_DIM);

  assign last_n    = (n_q == ac - CW'(1));
  assign last_elem = (r_q == ar - CW'(1)) && (c_q == bc - CW'(1));

  assign wr_addr_o   = ADDR_W'(32'(in_data_i.elem_row) * MAX_DIM + 32'(in_data_i.elem_col));
  assign rd_addr_a_o = ADDR_W'(32'(r_q) * MAX_DIM + 32'(n_q));
  assign rd_addr_b_o = ADDR_W'(32'(n_q) * MAX_DIM + 32'(c_q));

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    n_d     = n_q;
    cmd_o   = '0;
    cmd_o.out_row  = r_q[mm_pkg::POS_W-1:0];
    cmd_o.out_col  = c_q[mm_pkg::POS_W-1:0];
    cmd_o.first    = (n_q == '0);
    cmd_o.last_n   = last_n;
    cmd_o.out_last = last_elem;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.operation)
            mm_pkg::OP_LOAD_A: cmd_o.wr_a = in_range;
            mm_pkg::OP_LOAD_B: cmd_o.wr_b = in_range;
            mm_pkg::OP_COMPUTE: begin
              r_d = '0;
              c_d = '0;
              n_d = '0;
              state_d = dims_bad ? S_ERR : S_ISSUE;
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (last_n) begin
          n_d     = '0;
          state_d = S_WAIT;
        end else begin
          n_d = n_q + CW'(1);
        end
      end
      S_WAIT: begin
        // The finished sum moves to the output register once that slot is free.
        if (status_i.acc_done && status_i.slot_free) begin
          cmd_o.load_out = 1'b1;
          if (last_elem) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_ISSUE;
            if (c_q == bc - CW'(1)) begin
              c_d = '0;
              r_d = r_q + CW'(1);
            end else begin
              c_d = c_q + CW'(1);
            end
          end
        end
      end
      S_ERR: begin
        if (status_i.slot_free) begin
          cmd_o.load_err = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      r_q      <= '0;
      c_q      <= '0;
      n_q      <= '0;
      a_rows_q <= mm_pkg::DIM_RESET;
      a_cols_q <= mm_pkg::DIM_RESET;
      b_rows_q <= mm_pkg::DIM_RESET;
      b_cols_q <= mm_pkg::DIM_RESET;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      n_q     <= n_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          mm_pkg::REG_A_ROWS: a_rows_q <= cfg_data_i;
          mm_pkg::REG_A_COLS: a_cols_q <= cfg_data_i;
          mm_pkg::REG_B_ROWS: b_rows_q <= cfg_data_i;
          mm_pkg::REG_B_COLS: b_cols_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

[hw/rtl/mm_datapath.sv]
// ----------------------------------------------------------------------------
// Matrix multiply datapath
// Two element memories, a read / multiply / accumulate pipeline with
// 64-bit saturation, and the output register with its 32-bit clamp.
// ----------------------------------------------------------------------------
module mm_datapath #(
  parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mm_pkg::dp_cmd_t                       cmd_i,
  output mm_pkg::dp_status_t                    status_o,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    wr_addr_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    rd_addr_a_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    rd_addr_b_i,
  input  logic signed [mm_pkg::IN_VAL_W-1:0]    elem_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output mm_pkg::out_item_t                     out_data_o
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int EXT_W  = (ELEM_WIDTH > mm_pkg::IN_VAL_W) ? ELEM_WIDTH : mm_pkg::IN_VAL_W;
  localparam int ACC_W  = mm_pkg::ACC_W;
  localparam int OV_W   = mm_pkg::OUT_VAL_W;

  logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] b_mem [DEPTH];

  logic [EXT_W-1:0]             raw_ext;
  logic signed [ELEM_WIDTH-1:0] wr_data;
  logic signed [ELEM_WIDTH-1:0] rd_a_q, rd_b_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [ACC_W-1:0]      acc_q, acc_d, prod_ext, base, sum;
  logic signed [OV_W-1:0]       sat_val;
  logic                         v1_q, f1_q, l1_q, v2_q, f2_q, l2_q, done_q;
  logic                         overflow;
  mm_pkg::out_item_t            out_q;
  logic                         out_valid_q;

  // Element cut or zero-padded to ELEM_WIDTH bits; sign is the top kept bit.
  assign raw_ext = EXT_W'({elem_value_i});
  assign wr_data = raw_ext[ELEM_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      a_mem[wr_addr_i] <= wr_data;
    end
    if (cmd_i.wr_b) begin
      b_mem[wr_addr_i] <= wr_data;
    end
    rd_a_q <= a_mem[rd_addr_a_i];
    rd_b_q <= b_mem[rd_addr_b_i];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(rd_a_q) * PROD_W'(rd_b_q);
  end

  assign prod_ext = ACC_W'(prod_q);
  assign base     = f2_q ? '0 : acc_q;
  assign sum      = base + prod_ext;
  assign overflow = (base[ACC_W-1] == prod_ext[ACC_W-1]) && (sum[ACC_W-1] != base[ACC_W-1]);

  always_comb begin
    acc_d = sum;
    if (overflow) begin
      acc_d = base[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc_q <= acc_d;
    end
  end

  // Clamp the exact sum to the signed 32-bit range.
  always_comb begin
    sat_val = acc_q[OV_W-1:0];
    if (acc_q[ACC_W-1:OV_W-1] != {(ACC_W-OV_W+1){acc_q[ACC_W-1]}}) begin
      sat_val = acc_q[ACC_W-1] ? {1'b1, {(OV_W-1){1'b0}}} : {1'b0, {(OV_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      f1_q   <= 1'b0;
      l1_q   <= 1'b0;
      v2_q   <= 1'b0;
      f2_q   <= 1'b0;
      l2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      f1_q <= cmd_i.first;
      l1_q <= cmd_i.last_n;
      v2_q <= v1_q;
      f2_q <= f1_q;
      l2_q <= l1_q;
      if (cmd_i.load_out) begin
        done_q <= 1'b0;
      end else if (v2_q && l2_q) begin
        done_q <= 1'b1;
      end
    end
  end

  assign status_o.acc_done  = done_q;
  assign status_o.slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.out_row   <= cmd_i.out_row;
      out_q.out_col   <= cmd_i.out_col;
      out_q.out_value <= sat_val;
      out_q.status    <= mm_pkg::STATUS_OK;
      out_q.last      <= cmd_i.out_last;
    end else if (cmd_i.load_err) begin
      out_q.out_row   <= '0;
      out_q.out_col   <= '0;
      out_q.out_value <= '0;
      out_q.status    <= mm_pkg::STATUS_ERR;
      out_q.last      <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out || cmd_i.load_err) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/matrix_multiply_top.sv]
// Loads of A or B and unused operations are taken while idle; an empty or mismatched
// compute gives a single error result. A compute works out each product element with
// one read per inner step from each element memory, then the multiply and accumulate
// stages drain. Input is stalled for the whole compute run.
// Reset is asynchronous and active low; it sets all dimensions to 8 and empties the
// output register. Element memories are not cleared and hold no value until loaded.
// ----------------------------------------------------------------------------
// Matrix multiply top level
// Dense matrix product of two loaded Q8.8 matrices, emitted in row-major
// order as saturated Q16.16 elements.
// ----------------------------------------------------------------------------
module matrix_multiply_top #(
  parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mm_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  mm_pkg::in_item_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output mm_pkg::out_item_t            out_data_o
);

  localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);

  mm_pkg::dp_cmd_t    cmd;
  mm_pkg::dp_status_t status;
  logic [ADDR_W-1:0]  wr_addr, rd_addr_a, rd_addr_b;

  mm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .wr_addr_o   (wr_addr),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b)
  );

  mm_datapath #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .wr_addr_i    (wr_addr),
    .rd_addr_a_i  (rd_addr_a),
    .rd_addr_b_i  (rd_addr_b),
    .elem_value_i (in_data_i.elem_value),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

`ifndef SYNTH
  // A sum is handed to the output only after its last inner step has accumulated.
  a_load_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> status.acc_done)
    else $error("product element loaded before accumulation finished");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out || cmd.load_err) |-> status.slot_free)
    else $error("output register overwritten while a transfer was pending");

  // Memory writes come only from accepted load items.
  a_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.wr_a || cmd.wr_b) |-> (in_valid_i && !in_stall_o))
    else $error("element memory written without an accepted load");

  // Inner steps never run while an old sum still waits to be taken.
  a_issue_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !status.acc_done)
    else $error("inner step issued while a finished sum was pending");
`endif

endmodule
